// ----- hw/rtl/timestamped_keyed_table_macros.svh -----
// Assertion macros for the timestamped keyed table.
`ifndef TIMESTAMPED_KEYED_TABLE_MACROS_SVH
`define TIMESTAMPED_KEYED_TABLE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TKT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TKT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/tkt_pkg.sv -----
// Shared types, constants and codes for the timestamped keyed table.
`default_nettype none

package tkt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_SET_EX = 2'd2;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_NOT_NEWER = 3'd2;
  localparam logic [2:0] ST_SKIPPED   = 3'd3;
  localparam logic [2:0] ST_FOUND     = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;

  // Q16.16: -2.0 marks a skipped insert, -1.0 marks an absent entry.
  localparam logic signed [31:0] TOR_SKIP   = -32'sd131072;
  localparam logic signed [31:0] TOR_ABSENT = -32'sd65536;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        road_id;
    logic [31:0]        timestamp;
    logic signed [31:0] time_on_road;
    logic               exception_flag;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] found_time_on_road;
    logic               found_exception;
    logic [6:0]         entry_count;
  } rsp_t;

  typedef struct packed {
    logic               valid;
    logic [31:0]        road_id;
    logic [31:0]        timestamp;
    logic signed [31:0] time_on_road;
    logic               exception;
  } entry_t;

  // Controller to cell row.
  typedef struct packed {
    logic             shift;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_entry;
  } tbl_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tkt_cell.sv -----
// One table slot of the rotating ring: holds an entry, shifts or is written.
`default_nettype none

module tkt_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            shift,
  input  wire logic            wr_en,
  input  wire tkt_pkg::entry_t nb,
  input  wire tkt_pkg::entry_t wr_entry,
  output tkt_pkg::entry_t      entry
);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (wr_en) begin
      entry.valid <= wr_entry.valid;
    end else if (shift) begin
      entry.valid <= nb.valid;
    end
    if (wr_en) begin
      entry.road_id      <= wr_entry.road_id;
      entry.timestamp    <= wr_entry.timestamp;
      entry.time_on_road <= wr_entry.time_on_road;
      entry.exception    <= wr_entry.exception;
    end else if (shift) begin
      entry.road_id      <= nb.road_id;
      entry.timestamp    <= nb.timestamp;
      entry.time_on_road <= nb.time_on_road;
      entry.exception    <= nb.exception;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tkt_ctrl.sv -----
// Sequencer: scans the ring once per beat, then decides, writes and reports.
`default_nettype none

module tkt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire tkt_pkg::req_t   req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output tkt_pkg::rsp_t        rsp,
  input  wire tkt_pkg::entry_t head,
  output tkt_pkg::tbl_cmd_t    cmd
);

  tkt_pkg::state_t state, state_next;

  tkt_pkg::req_t              req_q;
  logic [tkt_pkg::IDX_W-1:0]  idx;
  logic                       m_found;
  logic [tkt_pkg::IDX_W-1:0]  m_idx;
  logic [31:0]                m_ts;
  logic signed [31:0]         m_tor;
  logic                       m_ex;
  logic                       f_found;
  logic [tkt_pkg::IDX_W-1:0]  f_idx;
  logic [6:0]                 count;

  logic       last;
  logic       shift;
  logic       commit;
  logic       do_write;
  logic       cnt_inc;
  logic [tkt_pkg::IDX_W-1:0] wr_idx;
  tkt_pkg::entry_t           wr_entry;
  tkt_pkg::rsp_t             rsp_next;

  assign last = (idx == tkt_pkg::IDX_W'(tkt_pkg::TABLE_DEPTH - 1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tkt_pkg::S_IDLE:   if (req_valid) state_next = tkt_pkg::S_SCAN;
      tkt_pkg::S_SCAN:   if (last) state_next = tkt_pkg::S_COMMIT;
      tkt_pkg::S_COMMIT: if (!rsp_valid || rsp_ready) state_next = tkt_pkg::S_IDLE;
      default:           state_next = tkt_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    req_ready = 1'b0;
    shift     = 1'b0;
    commit    = 1'b0;
    unique case (state)
      tkt_pkg::S_IDLE:   req_ready = 1'b1;
      tkt_pkg::S_SCAN:   shift = 1'b1;
      tkt_pkg::S_COMMIT: commit = !rsp_valid || rsp_ready;
      default:           ;
    endcase
  end

  // Decide the outcome from what the scan captured.
  always_comb begin
    do_write = 1'b0;
    cnt_inc  = 1'b0;
    wr_idx   = m_idx;
    wr_entry.valid        = 1'b1;
    wr_entry.road_id      = req_q.road_id;
    wr_entry.timestamp    = req_q.timestamp;
    wr_entry.time_on_road = req_q.time_on_road;
    wr_entry.exception    = req_q.exception_flag;
    rsp_next.found_time_on_road = '0;
    rsp_next.found_exception    = 1'b0;
    rsp_next.status             = tkt_pkg::ST_NOT_FOUND;
    if (req_q.action == tkt_pkg::ACT_INSERT) begin
      if (req_q.exception_flag && req_q.time_on_road == tkt_pkg::TOR_SKIP) begin
        rsp_next.status = tkt_pkg::ST_SKIPPED;
      end else if (m_found) begin
        if (m_ts < req_q.timestamp) begin
          do_write        = 1'b1;
          rsp_next.status = tkt_pkg::ST_UPDATED;
        end else begin
          rsp_next.status = tkt_pkg::ST_NOT_NEWER;
        end
      end else if (f_found) begin
        do_write        = 1'b1;
        cnt_inc         = 1'b1;
        wr_idx          = f_idx;
        rsp_next.status = tkt_pkg::ST_ADDED;
      end else begin
        rsp_next.status = tkt_pkg::ST_FULL;
      end
    end else if (m_found) begin
      // Lookup, set exception, and the unused code that acts as lookup.
      wr_entry.timestamp    = m_ts;
      wr_entry.time_on_road = m_tor;
      wr_entry.exception    = m_ex;
      if (req_q.action == tkt_pkg::ACT_SET_EX) begin
        do_write           = 1'b1;
        wr_entry.exception = req_q.exception_flag;
      end
      rsp_next.status             = tkt_pkg::ST_FOUND;
      rsp_next.found_time_on_road = m_tor;
      rsp_next.found_exception    = wr_entry.exception;
    end else begin
      rsp_next.found_time_on_road = tkt_pkg::TOR_ABSENT;
    end
    rsp_next.entry_count = cnt_inc ? count + 7'd1 : count;
  end

  assign cmd.shift    = shift;
  assign cmd.wr_en    = commit && do_write;
  assign cmd.wr_idx   = wr_idx;
  assign cmd.wr_entry = wr_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tkt_pkg::S_IDLE;
      idx       <= '0;
      m_found   <= 1'b0;
      f_found   <= 1'b0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (req_valid && req_ready) begin
        idx     <= '0;
        m_found <= 1'b0;
        f_found <= 1'b0;
      end else if (state == tkt_pkg::S_SCAN) begin
        idx <= last ? '0 : idx + tkt_pkg::IDX_W'(1);
        if (!m_found && head.valid && head.road_id == req_q.road_id) begin
          m_found <= 1'b1;
        end
        if (!f_found && !head.valid) begin
          f_found <= 1'b1;
        end
      end
      if (commit) begin
        count     <= rsp_next.entry_count;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
    if (state == tkt_pkg::S_SCAN) begin
      // Capture the first key match and the lowest free slot.
      if (!m_found && head.valid && head.road_id == req_q.road_id) begin
        m_idx <= idx;
        m_ts  <= head.timestamp;
        m_tor <= head.time_on_road;
        m_ex  <= head.exception;
      end
      if (!f_found && !head.valid) begin
        f_idx <= idx;
      end
    end
    if (commit) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/timestamped_keyed_table.sv -----
// A result is in the output register once the scan of the cell ring and the commit state are done.
// A new beat is taken only in the idle state, after a full rotation of the cell ring and the commit.
// The next beat is taken while the previous result still waits in the output register.
// Reset (synchronous, rst high) clears all valid bits and the entry count at once;
// slot payloads are undefined until written and there is no clearing pass.
`default_nettype none

module timestamped_keyed_table (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire tkt_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output tkt_pkg::rsp_t      rsp
);

  tkt_pkg::entry_t   cells [tkt_pkg::TABLE_DEPTH];
  tkt_pkg::tbl_cmd_t cmd;

  tkt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .head      (cells[0]),
    .cmd       (cmd)
  );

  // Ring: each cell takes its upper neighbor, the head wraps to the tail.
  for (genvar i = 0; i < tkt_pkg::TABLE_DEPTH; i++) begin : g_cell
    tkt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (cmd.shift),
      .wr_en    (cmd.wr_en && cmd.wr_idx == tkt_pkg::IDX_W'(i)),
      .nb       (cells[(i + 1) % tkt_pkg::TABLE_DEPTH]),
      .wr_entry (cmd.wr_entry),
      .entry    (cells[i])
    );
  end

`include "timestamped_keyed_table_macros.svh"

  `TKT_ASSERT_NEXT(a_busy_after_beat, req_valid && req_ready, !req_ready, "ready after beat")
  `TKT_ASSERT_NOW(a_write_not_shift, cmd.wr_en, !cmd.shift, "write during rotation")
  `TKT_ASSERT_NOW(a_cnt, rsp_valid, rsp.entry_count <= 7'(tkt_pkg::TABLE_DEPTH), "count high")
  `TKT_ASSERT_NEXT(a_write_reports, cmd.wr_en, rsp_valid, "no result after write")

endmodule

`default_nettype wire
